// ===== src/rvig_pkg.sv =====
// Shared types and constants for the radial vignette pixel pipeline.
// Used by rvig_divider and radial_vignette_pixel; no dependencies.
package rvig_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int STRENGTH_MAX = 200;

    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 2;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DIFF_W = (DIM_W > COORD_W + 1) ? DIM_W : COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int NUM_W  = SQ_W + 1;
    localparam int SN_W   = NUM_W + 8;
    localparam int DEN_W  = 2 * DIM_W + 8;
    localparam int CMP_W  = (SN_W > DEN_W) ? SN_W : DEN_W;
    localparam int Q_W    = FRAC_BITS + 1;

    localparam logic [IDX_W-1:0] REG_STRENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

endpackage

// ===== src/rvig_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, pixel carried along.
// Depends on rvig_pkg.
module rvig_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [rvig_pkg::DEN_W-1:0] in_rem,
    input  rvig_pkg::pix_t            in_pix,
    input  logic [rvig_pkg::DEN_W-1:0] den,
    output logic                      out_valid,
    output logic [rvig_pkg::Q_W-1:0]  out_q,
    output rvig_pkg::pix_t            out_pix
);
    import rvig_pkg::*;

    logic [Q_W-1:0]   valid_reg;
    logic [DEN_W-1:0] rem_reg [0:Q_W-1];
    logic [Q_W-1:0]   quo_reg [0:Q_W-1];
    pix_t             pix_reg [0:Q_W-1];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_step
            logic [DEN_W:0]   trial;
            logic [Q_W-1:0]   quo_src;
            logic             valid_src;
            pix_t             pix_src;
            logic             take;
            logic [DEN_W:0]   diff;
            logic [DEN_W-1:0] rem_next;
            logic [Q_W-1:0]   quo_next;

            if (k == 0)
            begin : g_first
                // first bit: remainder never exceeds the divisor, no shift
                assign trial     = {1'b0, in_rem};
                assign quo_src   = '0;
                assign valid_src = in_valid;
                assign pix_src   = in_pix;
            end
            else
            begin : g_rest
                assign trial     = {rem_reg[k-1], 1'b0};
                assign quo_src   = quo_reg[k-1];
                assign valid_src = valid_reg[k-1];
                assign pix_src   = pix_reg[k-1];
            end

            assign take     = (trial >= {1'b0, den});
            assign diff     = trial - {1'b0, den};
            assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            assign quo_next = {quo_src[Q_W-2:0], take};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= valid_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    quo_reg[k] <= quo_next;
                    pix_reg[k] <= pix_src;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[Q_W-1];
    assign out_q     = quo_reg[Q_W-1];
    assign out_pix   = pix_reg[Q_W-1];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[Q_W-1] |-> (rem_reg[Q_W-1] < den))
        else $error("divider remainder not below divisor");

    a_q_at_most_one: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[Q_W-1] && quo_reg[Q_W-1][Q_W-1]) |-> (quo_reg[Q_W-1][Q_W-2:0] == '0))
        else $error("vignette factor above unity");

endmodule

// ===== src/radial_vignette_pixel.sv =====
// Top level of the radial vignette pixel pipeline: config, distance, factor, scaling.
// Depends on rvig_pkg and rvig_divider.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  cfg      | cfg_we                | cfg_index, cfg_data
//  in       | in_valid / in_stall   | column, row_index, red_in, green_in, blue_in
//  out      | out_valid / out_stall | red_out, green_out, blue_out
//
// One request per clock while in_stall is low; a result passes through the five
// distance stages, the 17-stage quotient pipeline and the output register.
// Reset clears all valid bits; config goes to strength 0, 640 x 480.
// A one-entry skid ahead of the output register absorbs a stall; in_stall is that
// skid's full flag; while set the whole pipeline freezes and nothing is dropped.
module radial_vignette_pixel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rvig_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rvig_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rvig_pkg::COORD_W-1:0]  column,
    input  logic [rvig_pkg::COORD_W-1:0]  row_index,
    input  logic [rvig_pkg::CHAN_W-1:0]   red_in,
    input  logic [rvig_pkg::CHAN_W-1:0]   green_in,
    input  logic [rvig_pkg::CHAN_W-1:0]   blue_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rvig_pkg::CHAN_W-1:0]   red_out,
    output logic [rvig_pkg::CHAN_W-1:0]   green_out,
    output logic [rvig_pkg::CHAN_W-1:0]   blue_out
);
    import rvig_pkg::*;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (32'(d) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(d);
        return r;
    endfunction

    // config registers
    logic [7:0]       strength_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= 8'd0;
            width_reg    <= CFG_W'(640);
            height_reg   <= CFG_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STRENGTH: strength_reg <= cfg_data[7:0];
                REG_WIDTH:    width_reg    <= cfg_data;
                REG_HEIGHT:   height_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_clamp;
    logic [7:0]       s_clamp;

    assign w_clamp = clamp_dim(width_reg);
    assign h_clamp = clamp_dim(height_reg);
    assign s_clamp = (strength_reg > 8'(STRENGTH_MAX)) ? 8'(STRENGTH_MAX) : strength_reg;

    // divisor 100 * (w^2 + h^2), registered in wsq_reg/hsq_reg, then in den_reg
    logic [2*DIM_W-1:0] wsq_reg;
    logic [2*DIM_W-1:0] hsq_reg;
    logic [DEN_W-1:0]   den_reg;

    always_ff @(posedge clk)
    begin
        wsq_reg <= (2*DIM_W)'(w_clamp) * (2*DIM_W)'(w_clamp);
        hsq_reg <= (2*DIM_W)'(h_clamp) * (2*DIM_W)'(h_clamp);
        den_reg <= (DEN_W'(wsq_reg) + DEN_W'(hsq_reg)) * DEN_W'(100);
    end

    // pipeline control
    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // stage 1: distances from center, doubled
    logic [DIFF_W-1:0] x2;
    logic [DIFF_W-1:0] y2;
    logic [DIFF_W-1:0] wd;
    logic [DIFF_W-1:0] hd;
    logic [DIFF_W-1:0] dx_next;
    logic [DIFF_W-1:0] dy_next;
    pix_t              pix_in;

    assign x2 = DIFF_W'({column, 1'b0});
    assign y2 = DIFF_W'({row_index, 1'b0});
    assign wd = DIFF_W'(w_clamp);
    assign hd = DIFF_W'(h_clamp);
    assign dx_next = (x2 >= wd) ? (x2 - wd) : (wd - x2);
    assign dy_next = (y2 >= hd) ? (y2 - hd) : (hd - y2);
    assign pix_in  = '{red: red_in, green: green_in, blue: blue_in};

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [DIFF_W-1:0] dx1_reg, dy1_reg;
    logic [SQ_W-1:0]   sqx2_reg, sqy2_reg;
    logic [NUM_W-1:0]  num3_reg;
    logic [SN_W-1:0]   sn4_reg;
    logic [DEN_W-1:0]  rem5_reg;
    pix_t              pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix5_reg;

    // stage 5: numerator beyond divisor clamps the factor to zero
    logic [CMP_W-1:0] sn_ext;
    logic [CMP_W-1:0] den_ext;
    logic [CMP_W-1:0] rem_wide;
    logic [DEN_W-1:0] rem_next;

    assign sn_ext   = CMP_W'(sn4_reg);
    assign den_ext  = CMP_W'(den_reg);
    assign rem_wide = den_ext - sn_ext;
    assign rem_next = (sn_ext >= den_ext) ? '0 : rem_wide[DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;
            pix1_reg <= pix_in;
            sqx2_reg <= SQ_W'(dx1_reg) * SQ_W'(dx1_reg);
            sqy2_reg <= SQ_W'(dy1_reg) * SQ_W'(dy1_reg);
            pix2_reg <= pix1_reg;
            num3_reg <= NUM_W'(sqx2_reg) + NUM_W'(sqy2_reg);
            pix3_reg <= pix2_reg;
            sn4_reg  <= SN_W'(s_clamp) * SN_W'(num3_reg);
            pix4_reg <= pix3_reg;
            rem5_reg <= rem_next;
            pix5_reg <= pix4_reg;
        end
    end

    // factor = floor(rem * 2^F / den)
    logic           div_valid;
    logic [Q_W-1:0] div_q;
    pix_t           div_pix;

    rvig_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v5_reg),
        .in_rem    (rem5_reg),
        .in_pix    (pix5_reg),
        .den       (den_reg),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_pix   (div_pix)
    );

    // scale channels, truncate
    localparam int PROD_W = CHAN_W + Q_W;

    logic [PROD_W-1:0] prod_r, prod_g, prod_b;
    pix_t              scaled;
    logic              incoming;

    assign prod_r   = PROD_W'(div_pix.red)   * PROD_W'(div_q);
    assign prod_g   = PROD_W'(div_pix.green) * PROD_W'(div_q);
    assign prod_b   = PROD_W'(div_pix.blue)  * PROD_W'(div_q);
    assign scaled   = '{red:   prod_r[FRAC_BITS +: CHAN_W],
                        green: prod_g[FRAC_BITS +: CHAN_W],
                        blue:  prod_b[FRAC_BITS +: CHAN_W]};
    assign incoming = adv && div_valid;

    pix_t out_reg;
    pix_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_stall)
        begin
            if (incoming)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= incoming;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_stall)
        begin
            if (incoming)
                skid_reg <= scaled;
        end
        else if (skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (incoming)
        begin
            out_reg <= scaled;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_reg.red;
    assign green_out = out_reg.green;
    assign blue_out  = out_reg.blue;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request while output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid did not drain into output register");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed or vanished");

endmodule
